>>> hdl/rsd_pkg.sv
package rsd_pkg;

	// Width of one row element and of one sorted result.
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] elem_t;

endpackage

>>> hdl/row_sort_descending.sv
// Channel   Direction  Handshake              Payload
// row       in         row_valid/row_ready    element, row_end
// res       out        res_valid/res_ready    sorted_value, run_end, overflowed
//
// Elements are stored while the buffer has room. After the element that ends a row
// of n stored elements, one comparator walks the row buffer once per result, paced
// by the single RAM read port; pass p picks the largest of stored positions p to n-1.
// Each pass hands its largest value to the result register; a pass waits there while
// the previous result has not been taken. row_ready is low from the row end until the
// last result is loaded. Reset clears the control state; the buffer is not cleared.
module row_sort_descending import rsd_pkg::*; #(
	parameter int MAX_COLS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  row_valid,
	output logic  row_ready,
	input  elem_t element,
	input  logic  row_end,
	output logic  res_valid,
	input  logic  res_ready,
	output elem_t sorted_value,
	output logic  run_end,
	output logic  overflowed
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_READ_P,
		ST_SCAN,
		ST_PUSH
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   fill_q;
	logic            ovf_q;
	logic [CW-1:0]   p_q;
	logic [CW-1:0]   q_q;
	elem_t           cur_q;
	logic            res_valid_q;
	elem_t           res_value_q;
	logic            res_last_q;
	logic            res_ovf_q;

	logic [CW-1:0]   p_next;
	logic [CW-1:0]   q_next;
	logic            row_take;
	logic            row_full;
	logic            res_free;
	logic            res_load;
	logic            swap;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	elem_t           ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	assign p_next    = p_q + CW'(1);
	assign q_next    = q_q + CW'(1);
	assign row_ready = (state_q == ST_LOAD);
	assign row_take  = row_valid && row_ready;
	assign row_full  = (fill_q >= CW'(MAX_COLS));
	assign res_free  = !res_valid_q || res_ready;
	assign res_load  = (state_q == ST_PUSH) && res_free;
	assign swap      = (state_q == ST_SCAN) && (cur_q < $signed(ram_rdata));

	// Buffer port selection: loading writes the next slot, a scan writes back the
	// displaced value and reads one position ahead.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fill_q[AW-1:0];
		ram_wdata = element;
		ram_raddr = p_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				ram_we = row_take && !row_full;
			end
			ST_READ_P: begin
				ram_raddr = p_next[AW-1:0];
			end
			ST_SCAN: begin
				ram_we    = swap;
				ram_waddr = q_q[AW-1:0];
				ram_wdata = cur_q;
				ram_raddr = q_next[AW-1:0];
			end
			default: begin
				ram_raddr = p_q[AW-1:0];
			end
		endcase
	end

	rsd_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_COLS)
	) u_row_buf (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// Sequencer, comparator register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			p_q         <= '0;
			q_q         <= '0;
			cur_q       <= '0;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_last_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			// The result register fills from a finished pass or empties when taken.
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (row_take) begin
						if (row_full) begin
							ovf_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
						if (row_end) begin
							p_q     <= '0;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_READ_P;
				end
				ST_READ_P: begin
					cur_q <= $signed(ram_rdata);
					q_q   <= p_next;
					if (p_next < fill_q) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_SCAN: begin
					if (swap) begin
						cur_q <= $signed(ram_rdata);
					end
					q_q <= q_next;
					if (q_next >= fill_q) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (res_load) begin
						res_value_q <= cur_q;
						res_last_q  <= (p_next == fill_q);
						res_ovf_q   <= ovf_q;
						if (p_next == fill_q) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							p_q     <= p_next;
							state_q <= ST_START;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign res_valid    = res_valid_q;
	assign sorted_value = res_value_q;
	assign run_end      = res_last_q;
	assign overflowed   = res_ovf_q;

endmodule

>>> hdl/rsd_ram.sv
module rsd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/rsd_checker.sv
module rsd_checker import rsd_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  row_valid,
	input logic  row_ready,
	input elem_t element,
	input logic  row_end,
	input logic  res_valid,
	input logic  res_ready,
	input elem_t sorted_value,
	input logic  run_end,
	input logic  overflowed
);

	logic  open_q;
	elem_t prev_q;
	logic  ovf_q;

	// Remember the previous result of a row that is still being delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			open_q <= !run_end;
			prev_q <= sorted_value;
			ovf_q  <= overflowed;
		end
	end

	// A stalled result keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(sorted_value)))
		else $error("result changed while stalled");

	// Accepting the end of a row closes the input.
	a_row_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && row_end) |=> !row_ready)
		else $error("input accepted right after row end");

	// While a row loads, the input stays open.
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && row_ready && !row_end) |=> row_ready)
		else $error("input closed in the middle of a row");

	// Results of one row come out largest first.
	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && open_q) |-> (sorted_value <= prev_q))
		else $error("results not in descending order");

	// The overflow flag is the same on every result of a row.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && open_q) |-> (overflowed == ovf_q))
		else $error("overflow flag changed within a row");

endmodule

bind row_sort_descending rsd_checker u_rsd_checker (.*);
